### rtl/process_table_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Process table scheduler assertion macros
// Shared concurrent assertion forms used by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef PROCESS_TABLE_SCHEDULER_MACROS_SVH
`define PROCESS_TABLE_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// Process table scheduler package
// Beat types, codes and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STACK_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STACK_STRIDE = 1'b1;

    localparam logic [15:0] KERNEL_ADDR      = 16'h8100;
    localparam logic [15:0] STACK_BASE_RST   = 16'h5000;
    localparam logic [11:0] STACK_STRIDE_RST = 12'h200;

    typedef enum logic [2:0] {
        CMD_START     = 3'd0,
        CMD_EXIT_ADDR = 3'd1,
        CMD_FORK      = 3'd2,
        CMD_EXIT_RUN  = 3'd3,
        CMD_WAIT      = 3'd4,
        CMD_SCHED     = 3'd5
    } t_command;

    typedef enum logic [1:0] {
        RC_OK         = 2'd0,
        RC_NO_FREE    = 2'd1,
        RC_NOT_FOUND  = 2'd2,
        RC_FORK_CHILD = 2'd3
    } t_result_code;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_SUSP  = 2'd1,
        ST_READY = 2'd2
    } t_slot_state;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_FREE_SCAN,
        CS_MATCH_SCAN,
        CS_FORK_CHK,
        CS_EXIT_CUR,
        CS_EXIT_PAR,
        CS_SUSPEND,
        CS_RR_SCAN,
        CS_FINISH
    } t_ctrl_state;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ONE,
        PTR_CUR,
        PTR_CUR_NEXT,
        PTR_PARENT,
        PTR_INC
    } t_ptr_op;

    typedef enum logic [1:0] {
        ADDR_ZERO,
        ADDR_IN,
        ADDR_SAVED
    } t_addr_src;

    typedef enum logic [1:0] {
        SLOT_ZERO,
        SLOT_PTR,
        SLOT_CUR
    } t_slot_src;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] program_addr;
    } t_cmd_beat;

    typedef struct packed {
        t_result_code result_code;
        logic [2:0]   slot_index;
        logic [15:0]  entry_addr;
        logic [15:0]  stack_addr;
        logic [2:0]   running_slot;
    } t_rsp_beat;

    typedef struct packed {
        logic         in_load;
        t_ptr_op      ptr_op;
        logic         st_we;
        t_slot_state  st_val;
        logic         par_we;
        logic         par_cur;
        logic         addr_we;
        t_addr_src    addr_src;
        logic         save_addr;
        logic         cur_load;
        logic         out_load;
        t_result_code code;
        t_slot_src    slot_src;
        t_addr_src    ent_src;
        logic         stack_en;
    } t_dp_cmd;

    typedef struct packed {
        t_slot_state rd_state;
        logic        addr_match;
        logic        parent_nz;
        logic        last_lin;
        logic        last_rr;
        logic        out_free;
    } t_dp_status;

endpackage

### rtl/process_table_scheduler.sv
// ----------------------------------------------------------------------------
// Process table scheduler
// Round-robin process table: start, exit, fork, wait and schedule commands.
// ----------------------------------------------------------------------------
//   Channel   Direction  Signals                          Beat
//   command   in         i_cmd_valid / o_cmd_stall        t_cmd_beat i_cmd
//   result    out        o_rsp_valid / i_rsp_stall        t_rsp_beat o_rsp
//   config    in         i_cfg_we, i_cfg_idx, i_cfg_wdata write only
//
// One command is taken at a time; it walks the slot table one entry per cycle
// through a single read port. From acceptance to a loaded result, a command
// runs through its scan over the slots; an unused code goes straight to the
// finish state, and a fork or a wait can scan every other slot. The result
// register lets the next command be accepted while a result beat is still
// stalled. Reset is synchronous and restores the kernel slot, the running
// slot and the stack settings at once.
// ----------------------------------------------------------------------------
module process_table_scheduler
    import pts_pkg::*;
#(
    parameter int NUM_SLOTS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_stall,
    input  t_cmd_beat             i_cmd,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_stall,
    output t_rsp_beat             o_rsp
);

    t_dp_cmd    w_dp_cmd;
    t_dp_status w_dp_st;

    pts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .i_command   (i_cmd.command),
        .o_cmd_stall (o_cmd_stall),
        .o_dp        (w_dp_cmd),
        .i_st        (w_dp_st)
    );

    pts_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_program_addr (i_cmd.program_addr),
        .i_cmd          (w_dp_cmd),
        .o_st           (w_dp_st),
        .o_rsp_valid    (o_rsp_valid),
        .i_rsp_stall    (i_rsp_stall),
        .o_rsp          (o_rsp)
    );

endmodule

### rtl/pts_ctrl.sv
// ----------------------------------------------------------------------------
// Process table scheduler controller
// Sequences each command over the table one slot per cycle.
// ----------------------------------------------------------------------------
module pts_ctrl
    import pts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  logic [2:0] i_command,
    output logic       o_cmd_stall,
    output t_dp_cmd    o_dp,
    input  t_dp_status i_st
);

    t_ctrl_state  r_state, n_state;
    logic [2:0]   r_cmd, n_cmd;
    t_result_code r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_cmd   <= '0;
            r_code  <= RC_OK;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_code  <= n_code;
        end
    end

    assign o_cmd_stall = (r_state != CS_IDLE);

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_code  = r_code;
        o_dp    = '0;
        unique case (r_state)
            CS_IDLE: begin
                if (i_cmd_valid) begin
                    o_dp.in_load = 1'b1;
                    n_cmd        = i_command;
                    n_code       = RC_OK;
                    unique case (i_command) inside
                        CMD_START: begin
                            o_dp.ptr_op = PTR_ONE;
                            n_state     = CS_FREE_SCAN;
                        end
                        CMD_EXIT_ADDR: begin
                            o_dp.ptr_op = PTR_ONE;
                            n_state     = CS_MATCH_SCAN;
                        end
                        CMD_FORK: begin
                            o_dp.ptr_op = PTR_CUR;
                            n_state     = CS_FORK_CHK;
                        end
                        CMD_EXIT_RUN: begin
                            o_dp.ptr_op = PTR_CUR;
                            n_state     = CS_EXIT_CUR;
                        end
                        CMD_WAIT: begin
                            o_dp.ptr_op = PTR_CUR;
                            n_state     = CS_SUSPEND;
                        end
                        CMD_SCHED: begin
                            o_dp.ptr_op = PTR_CUR_NEXT;
                            n_state     = CS_RR_SCAN;
                        end
                        default: begin
                            n_state = CS_FINISH;
                        end
                    endcase
                end
            end
            CS_FREE_SCAN: begin
                if (i_st.rd_state == ST_FREE) begin
                    // Claim the slot; a forked child takes its parent's program.
                    o_dp.st_we    = 1'b1;
                    o_dp.st_val   = ST_READY;
                    o_dp.par_we   = 1'b1;
                    o_dp.par_cur  = (r_cmd == CMD_FORK);
                    o_dp.addr_we  = 1'b1;
                    o_dp.addr_src = (r_cmd == CMD_FORK) ? ADDR_SAVED : ADDR_IN;
                    n_state       = CS_FINISH;
                end else if (i_st.last_lin) begin
                    n_code  = RC_NO_FREE;
                    n_state = CS_FINISH;
                end else begin
                    o_dp.ptr_op = PTR_INC;
                end
            end
            CS_MATCH_SCAN: begin
                if (i_st.rd_state != ST_FREE && i_st.addr_match) begin
                    o_dp.st_we    = 1'b1;
                    o_dp.st_val   = ST_FREE;
                    o_dp.par_we   = 1'b1;
                    o_dp.addr_we  = 1'b1;
                    o_dp.addr_src = ADDR_ZERO;
                    n_state       = CS_FINISH;
                end else if (i_st.last_lin) begin
                    n_code  = RC_NOT_FOUND;
                    n_state = CS_FINISH;
                end else begin
                    o_dp.ptr_op = PTR_INC;
                end
            end
            CS_FORK_CHK: begin
                o_dp.save_addr = 1'b1;
                if (i_st.parent_nz) begin
                    n_code  = RC_FORK_CHILD;
                    n_state = CS_FINISH;
                end else begin
                    o_dp.ptr_op = PTR_ONE;
                    n_state     = CS_FREE_SCAN;
                end
            end
            CS_EXIT_CUR: begin
                // Free the running slot and move over to its parent entry.
                o_dp.st_we  = 1'b1;
                o_dp.st_val = ST_FREE;
                o_dp.par_we = 1'b1;
                o_dp.ptr_op = PTR_PARENT;
                n_state     = CS_EXIT_PAR;
            end
            CS_EXIT_PAR: begin
                if (i_st.rd_state == ST_SUSP) begin
                    o_dp.st_we  = 1'b1;
                    o_dp.st_val = ST_READY;
                end
                n_state = CS_FINISH;
            end
            CS_SUSPEND: begin
                o_dp.st_we  = 1'b1;
                o_dp.st_val = ST_SUSP;
                o_dp.ptr_op = PTR_CUR_NEXT;
                n_state     = CS_RR_SCAN;
            end
            CS_RR_SCAN: begin
                if (i_st.rd_state == ST_READY) begin
                    o_dp.cur_load = 1'b1;
                    n_state       = CS_FINISH;
                end else if (i_st.last_rr) begin
                    n_state = CS_FINISH;
                end else begin
                    o_dp.ptr_op = PTR_INC;
                end
            end
            CS_FINISH: begin
                o_dp.code = r_code;
                if (r_code != RC_OK) begin
                    o_dp.slot_src = SLOT_ZERO;
                end else if (r_cmd == CMD_START || r_cmd == CMD_EXIT_ADDR ||
                             r_cmd == CMD_FORK) begin
                    o_dp.slot_src = SLOT_PTR;
                end else begin
                    o_dp.slot_src = SLOT_CUR;
                end
                if (r_code == RC_OK && r_cmd == CMD_START) begin
                    o_dp.ent_src  = ADDR_IN;
                    o_dp.stack_en = 1'b1;
                end else if (r_code == RC_OK && r_cmd == CMD_FORK) begin
                    o_dp.ent_src  = ADDR_SAVED;
                    o_dp.stack_en = 1'b1;
                end else begin
                    o_dp.ent_src = ADDR_ZERO;
                end
                if (i_st.out_free) begin
                    o_dp.out_load = 1'b1;
                    n_state       = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

endmodule

### rtl/pts_datapath.sv
// ----------------------------------------------------------------------------
// Process table scheduler datapath
// Slot table, running slot, scan pointer, stack arithmetic and result register.
// ----------------------------------------------------------------------------
`include "process_table_scheduler_macros.svh"

module pts_datapath
    import pts_pkg::*;
#(
    parameter int NUM_SLOTS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [15:0]           i_program_addr,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_st,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_stall,
    output t_rsp_beat             o_rsp
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] nxt;
        nxt = (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
        return nxt;
    endfunction

    t_slot_state       r_state  [NUM_SLOTS];
    logic [SLOT_W-1:0] r_parent [NUM_SLOTS];
    logic [15:0]       r_addr   [NUM_SLOTS];
    logic [SLOT_W-1:0] r_cur;
    logic [SLOT_W-1:0] r_ptr, n_ptr;
    logic [15:0]       r_base;
    logic [11:0]       r_stride;
    logic [15:0]       r_in_addr;
    logic [15:0]       r_sav_addr;
    logic              r_rsp_valid;
    t_rsp_beat         r_rsp;

    t_slot_state       w_rd_state;
    logic [SLOT_W-1:0] w_rd_parent;
    logic [15:0]       w_rd_addr;
    logic [SLOT_W-1:0] w_ptr_inc;
    logic [SLOT_W-1:0] w_idx_m1;
    logic [SLOT_W+11:0] w_prod;
    logic [15:0]       w_stack;
    logic [15:0]       w_wr_addr;
    logic              w_out_free;

    // Single read port: every access goes through the scan pointer.
    assign w_rd_state  = r_state[r_ptr];
    assign w_rd_parent = r_parent[r_ptr];
    assign w_rd_addr   = r_addr[r_ptr];
    assign w_ptr_inc   = next_slot(r_ptr);
    assign w_out_free  = !r_rsp_valid || !i_rsp_stall;

    assign o_st.rd_state   = w_rd_state;
    assign o_st.addr_match = (w_rd_addr == r_in_addr);
    assign o_st.parent_nz  = (w_rd_parent != '0);
    assign o_st.last_lin   = (r_ptr == LAST_SLOT);
    assign o_st.last_rr    = (w_ptr_inc == r_cur);
    assign o_st.out_free   = w_out_free;

    // Stack of slot i is base + (i - 1) * stride, wrapping at 16 bits.
    assign w_idx_m1 = r_ptr - SLOT_W'(1);
    assign w_prod   = (SLOT_W+12)'(w_idx_m1) * (SLOT_W+12)'(r_stride);
    assign w_stack  = r_base + 16'(w_prod);

    always_comb begin
        case (i_cmd.addr_src)
            ADDR_IN:    w_wr_addr = r_in_addr;
            ADDR_SAVED: w_wr_addr = r_sav_addr;
            default:    w_wr_addr = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.ptr_op)
            PTR_HOLD:     n_ptr = r_ptr;
            PTR_ONE:      n_ptr = SLOT_W'(1);
            PTR_CUR:      n_ptr = r_cur;
            PTR_CUR_NEXT: n_ptr = next_slot(r_cur);
            PTR_PARENT:   n_ptr = w_rd_parent;
            PTR_INC:      n_ptr = w_ptr_inc;
            default:      n_ptr = r_ptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_state[i]  <= (i == 0) ? ST_READY : ST_FREE;
                r_parent[i] <= '0;
                r_addr[i]   <= (i == 0) ? KERNEL_ADDR : '0;
            end
            r_cur       <= '0;
            r_ptr       <= '0;
            r_base      <= STACK_BASE_RST;
            r_stride    <= STACK_STRIDE_RST;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cmd.st_we) begin
                r_state[r_ptr] <= i_cmd.st_val;
            end
            if (i_cmd.par_we) begin
                r_parent[r_ptr] <= i_cmd.par_cur ? r_cur : '0;
            end
            if (i_cmd.addr_we) begin
                r_addr[r_ptr] <= w_wr_addr;
            end
            if (i_cmd.cur_load) begin
                r_cur <= r_ptr;
            end
            r_ptr <= n_ptr;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IDX_STACK_BASE:   r_base   <= i_cfg_wdata;
                    CFG_IDX_STACK_STRIDE: r_stride <= i_cfg_wdata[11:0];
                    default:              r_base   <= r_base;
                endcase
            end
            if (i_cmd.out_load) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_in_addr <= i_program_addr;
        end
        if (i_cmd.save_addr) begin
            r_sav_addr <= w_rd_addr;
        end
        if (i_cmd.out_load) begin
            r_rsp.result_code  <= i_cmd.code;
            r_rsp.running_slot <= 3'(r_cur);
            r_rsp.stack_addr   <= i_cmd.stack_en ? w_stack : '0;
            case (i_cmd.slot_src)
                SLOT_PTR: r_rsp.slot_index <= 3'(r_ptr);
                SLOT_CUR: r_rsp.slot_index <= 3'(r_cur);
                default:  r_rsp.slot_index <= '0;
            endcase
            case (i_cmd.ent_src)
                ADDR_IN:    r_rsp.entry_addr <= r_in_addr;
                ADDR_SAVED: r_rsp.entry_addr <= r_sav_addr;
                default:    r_rsp.entry_addr <= '0;
            endcase
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    `PTS_ASSERT_NOW(a_no_rsp_overwrite, i_clk, i_rst_n, i_cmd.out_load, w_out_free, "result beat overwritten while stalled")
    `PTS_ASSERT_NOW(a_sched_ready, i_clk, i_rst_n, i_cmd.cur_load, w_rd_state == ST_READY, "scheduled slot is not ready")
    `PTS_ASSERT_NOW(a_alloc_ready, i_clk, i_rst_n, i_cmd.out_load && i_cmd.stack_en, (i_cmd.code == RC_OK) && (w_rd_state == ST_READY), "allocated slot not ready")
    `PTS_ASSERT_NEXT(a_ptr_in_range, i_clk, i_rst_n, 1'b1, r_ptr <= LAST_SLOT, "scan pointer beyond last slot")

endmodule
